/* rtl/rwrl_pkg.sv */
// ----------------------------------------------------------------------------
// Reader/writer range lock table package
// Shared command and status codes and the control structs that pass between
// the top level and the lock table.
// ----------------------------------------------------------------------------
package rwrl_pkg;

  // Width of the slot index field on the request and result beats.
  localparam int unsigned SlotW = 4;
  // Width of the address fields on the request beat.
  localparam int unsigned PortAddrW = 32;
  // Width of the command field.
  localparam int unsigned CmdW = 2;

  // Command codes. The command is decoded on its bits: the high bit marks an
  // unlock (so the unused fourth code also unlocks), the low bit a write lock.
  localparam logic [CmdW-1:0] CMD_READ_LOCK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE_LOCK = 2'd1;
  localparam logic [CmdW-1:0] CMD_UNLOCK     = 2'd2;
  localparam int unsigned CmdUnlockBit = 1;
  localparam int unsigned CmdWriteBit  = 0;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_HELD     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Table update issued when a request leaves the input register.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [SlotW-1:0] slot;
    logic             wr_lock;
  } tbl_upd_t;

  // Lookup answers for the request held in the input register.
  typedef struct packed {
    logic in_table;
    logic slot_valid;
    logic conflict;
  } tbl_look_t;

endpackage

/* rtl/rwrl_table.sv */
// ----------------------------------------------------------------------------
// Reader/writer range lock table storage
// Holds one entry per slot and compares every entry against the current
// request in parallel, one overlap comparator pair per slot.
// ----------------------------------------------------------------------------
module rwrl_table import rwrl_pkg::*; #(
  parameter int unsigned LOCK_SLOTS   = 16,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [SlotW-1:0]        req_slot_i,
  input  logic                    req_write_i,
  input  logic [ADDRESS_BITS-1:0] req_start_i,
  input  logic [ADDRESS_BITS-1:0] req_end_i,
  input  tbl_upd_t                upd_i,
  output tbl_look_t               look_o
);

  logic [LOCK_SLOTS-1:0]   valid_q;
  logic [LOCK_SLOTS-1:0]   wr_mark_q;
  logic [ADDRESS_BITS-1:0] start_q [LOCK_SLOTS];
  logic [ADDRESS_BITS-1:0] end_q   [LOCK_SLOTS];

  logic [LOCK_SLOTS-1:0] req_sel;
  logic [LOCK_SLOTS-1:0] upd_sel;
  logic [LOCK_SLOTS-1:0] conflict_lane;

  for (genvar i = 0; i < LOCK_SLOTS; i++) begin : g_lane
    // Slot decode for the lookup and for the update.
    assign req_sel[i] = (32'(req_slot_i) == 32'(i));
    assign upd_sel[i] = (32'(upd_i.slot) == 32'(i));

    // A read request only collides with write entries; a write with any.
    assign conflict_lane[i] = valid_q[i] && (req_write_i || wr_mark_q[i]) &&
                              (start_q[i] <= req_end_i) && (end_q[i] >= req_start_i);

    // Valid bit per slot, cleared by reset.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (upd_sel[i] && upd_i.set) begin
        valid_q[i] <= 1'b1;
      end else if (upd_sel[i] && upd_i.clr) begin
        valid_q[i] <= 1'b0;
      end
    end

    // Entry payload, only meaningful while the slot is valid.
    always_ff @(posedge clk_i) begin
      if (upd_sel[i] && upd_i.set) begin
        wr_mark_q[i] <= upd_i.wr_lock;
        start_q[i]   <= req_start_i;
        end_q[i]     <= req_end_i;
      end
    end
  end

  // Reduce the lanes into the answers for the current request.
  assign look_o.in_table   = |req_sel;
  assign look_o.slot_valid = |(req_sel & valid_q);
  assign look_o.conflict   = |conflict_lane;

endmodule

/* rtl/reader_writer_range_lock_table_unit.sv */
// ----------------------------------------------------------------------------
// Reader/writer range lock table unit
// Grants, refuses and releases address-range locks held in a slot table.
// ----------------------------------------------------------------------------
// The unit takes one request beat per clock cycle and answers each with one
// result beat: the request is captured in an input register, checked
// combinationally against every slot of the table by a row of parallel
// overlap comparators, and its status is captured in a result register, from
// which it is offered, while the table is updated on the same edge, so the
// next request already sees the effect of this one. Throughput is one beat
// per cycle as long as results are taken; a stalled result register holds
// the input register, which then holds the input channel.
// ----------------------------------------------------------------------------
module reader_writer_range_lock_table_unit import rwrl_pkg::*; #(
  parameter int unsigned LOCK_SLOTS   = 16,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [SlotW-1:0]     slot_index_i,
  input  logic [PortAddrW-1:0] range_start_i,
  input  logic [PortAddrW-1:0] range_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [SlotW-1:0]     slot_echo_o
);

  // Input register.
  logic                 in_vld_q;
  logic [CmdW-1:0]      cmd_q;
  logic [SlotW-1:0]     slot_q;
  logic [PortAddrW-1:0] start_q;
  logic [PortAddrW-1:0] end_q;

  // Result register.
  logic             out_vld_q;
  status_e          status_q, status_d;
  logic [SlotW-1:0] echo_q;

  logic      advance;
  logic      fire;
  logic      is_unlock;
  logic      want_wr;
  tbl_look_t look;
  tbl_upd_t  upd;

  // The input stage moves on whenever the result register is free or drains.
  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      slot_q  <= slot_index_i;
      start_q <= range_start_i;
      end_q   <= range_end_i;
    end
  end

  assign is_unlock = cmd_q[CmdUnlockBit];
  assign want_wr   = cmd_q[CmdWriteBit];

  // Slot table with its parallel overlap check.
  rwrl_table #(
    .LOCK_SLOTS  (LOCK_SLOTS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_slot_i (slot_q),
    .req_write_i(want_wr),
    .req_start_i(ADDRESS_BITS'(start_q)),
    .req_end_i  (ADDRESS_BITS'(end_q)),
    .upd_i      (upd),
    .look_o     (look)
  );

  // Decide the status; the slot checks come before the conflict check.
  always_comb begin
    status_d    = ST_DONE;
    upd.set     = 1'b0;
    upd.clr     = 1'b0;
    upd.slot    = slot_q;
    upd.wr_lock = want_wr;
    if (is_unlock) begin
      if (!look.slot_valid) begin
        status_d = ST_EMPTY;
      end else begin
        upd.clr = fire;
      end
    end else if (!look.in_table || look.slot_valid) begin
      status_d = ST_HELD;
    end else if (look.conflict) begin
      status_d = ST_CONFLICT;
    end else begin
      upd.set = fire;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      echo_q   <= slot_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign slot_echo_o = echo_q;

endmodule

/* bench/tb_reader_writer_range_lock_table_unit.sv */
// ----------------------------------------------------------------------------
// Reader/writer range lock table unit testbench
// Drives lock and unlock requests into the unit and checks every answer
// against a shadow copy of the slot table kept in the bench. A directed pass
// covers the corner cases first, then random traffic follows under several
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reader_writer_range_lock_table_unit;
  import rwrl_pkg::*;

  localparam int unsigned LockSlots  = 16;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned CycleLimit = 200000;
  // The unused fourth command code; the unit decodes it as an unlock.
  localparam logic [CmdW-1:0] CmdUnlockAlt = CMD_UNLOCK | CMD_WRITE_LOCK;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_e;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
  } lock_answer_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [CmdW-1:0]      cmd_i         = CMD_READ_LOCK;
  logic [SlotW-1:0]     slot_index_i  = '0;
  logic [PortAddrW-1:0] range_start_i = '0;
  logic [PortAddrW-1:0] range_end_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [1:0]           status_o;
  logic [SlotW-1:0]     slot_echo_o;

  // Shadow of the slot table, updated as each request beat is accepted.
  logic                 held_valid [LockSlots];
  logic                 held_write [LockSlots];
  logic [PortAddrW-1:0] held_lo    [LockSlots];
  logic [PortAddrW-1:0] held_hi    [LockSlots];

  lock_answer_t pending_answers_q[$];
  int unsigned  err_cnt    = 0;
  int unsigned  cycle_cnt  = 0;
  bit           gaps_on    = 1'b0;
  int unsigned  burst_left = 0;
  rx_mode_e     rx_mode    = RX_ALWAYS;

  reader_writer_range_lock_table_unit #(
    .LOCK_SLOTS  (LockSlots),
    .ADDRESS_BITS(AddrBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .slot_index_i (slot_index_i),
    .range_start_i(range_start_i),
    .range_end_i  (range_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .slot_echo_o  (slot_echo_o)
  );

  // Clock generation.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog: a run that goes this long has hung.
  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("tb_reader_writer_range_lock_table_unit NOT OK");
    $finish;
  end

  // Receiver back-pressure, following the pattern of the current mode.
  always @(posedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      default:   out_ready_i <= ((cycle_cnt % 23) >= 7) && ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    foreach (held_valid[i]) begin
      held_valid[i] = 1'b0;
      held_write[i] = 1'b0;
      held_lo[i]    = '0;
      held_hi[i]    = '0;
    end
  end

  // Applies one request to the shadow table and returns the status it earns.
  function automatic status_e grant_or_refuse(input logic [CmdW-1:0]      cmd,
                                              input logic [SlotW-1:0]     slot,
                                              input logic [PortAddrW-1:0] lo,
                                              input logic [PortAddrW-1:0] hi);
    status_e st;
    logic    in_table;
    logic    want_write;
    st         = ST_DONE;
    in_table   = (slot < LockSlots);
    want_write = cmd[CmdWriteBit];
    if (cmd[CmdUnlockBit]) begin
      if (!in_table || !held_valid[slot]) st = ST_EMPTY;
      else held_valid[slot] = 1'b0;
    end else if (!in_table || held_valid[slot]) begin
      st = ST_HELD;
    end else begin
      // A reader only clashes with writers; a writer clashes with everyone.
      for (int i = 0; i < LockSlots; i++) begin
        if (held_valid[i] && (want_write || held_write[i]) &&
            held_lo[i] <= hi && held_hi[i] >= lo) begin
          st = ST_CONFLICT;
        end
      end
      if (st == ST_DONE) begin
        held_valid[slot] = 1'b1;
        held_write[slot] = want_write;
        held_lo[slot]    = lo;
        held_hi[slot]    = hi;
      end
    end
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch: %s, got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Predicts on every accepted request beat and checks every result beat.
  always @(posedge clk_i) begin : answer_check
    lock_answer_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want.status = grant_or_refuse(cmd_i, slot_index_i, range_start_i, range_end_i);
        want.slot   = slot_index_i;
        pending_answers_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_answers_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", 32'(status_o), 32'd0);
        end else begin
          want = pending_answers_q.pop_front();
          if (status_o !== want.status) begin
            report_mismatch("status", 32'(status_o), 32'(want.status));
          end
          if (slot_echo_o !== want.slot) begin
            report_mismatch("slot echo", 32'(slot_echo_o), 32'(want.slot));
          end
        end
      end
    end
  end

  // Sends one request beat, inserting a random gap at the end of each burst when gaps are enabled.
  task automatic send_request(input logic [CmdW-1:0]      cmd,
                              input logic [SlotW-1:0]     slot,
                              input logic [PortAddrW-1:0] lo,
                              input logic [PortAddrW-1:0] hi);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i    <= 1'b0;
        cmd_i         <= CmdW'($urandom);
        slot_index_i  <= SlotW'($urandom);
        range_start_i <= $urandom;
        range_end_i   <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    slot_index_i  <= slot;
    range_start_i <= lo;
    range_end_i   <= hi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Draws a range, mostly small and clustered so that locks meet each other.
  function automatic void pick_range(output logic [PortAddrW-1:0] lo,
                                     output logic [PortAddrW-1:0] hi);
    logic [PortAddrW-1:0] base;
    logic [PortAddrW-1:0] tmp;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = 32'h7FFF_FE00;
      2:       base = 32'hFFFF_FC00;
      default: base = $urandom & 32'hFFFF_F000;
    endcase
    lo = base + $urandom_range(0, 1023);
    hi = lo + $urandom_range(0, 63);
    case ($urandom_range(0, 15))
      0: begin
        lo = $urandom;
        hi = $urandom;
      end
      1: begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      2: hi = lo;
      3: hi = '1;
      4: lo = '0;
      default: ;
    endcase
  endfunction

  // Random traffic: mostly locks on free slots and unlocks of held ones,
  // with a share of fully random requests to hit held and empty slots.
  task automatic run_random_traffic(input int unsigned n);
    logic [CmdW-1:0]      cmd;
    logic [SlotW-1:0]     slot;
    logic [PortAddrW-1:0] lo;
    logic [PortAddrW-1:0] hi;
    int unsigned          held_cnt;
    int unsigned          first;
    logic                 want_lock;
    repeat (n) begin
      held_cnt = 0;
      foreach (held_valid[i]) if (held_valid[i]) held_cnt++;
      pick_range(lo, hi);
      if ($urandom_range(0, 99) < 20) begin
        cmd  = CmdW'($urandom_range(0, 3));
        slot = SlotW'($urandom);
      end else begin
        want_lock = (held_cnt == 0) ||
                    (held_cnt < LockSlots && $urandom_range(0, LockSlots - 1) >= held_cnt);
        first     = $urandom_range(0, LockSlots - 1);
        slot      = SlotW'(first);
        for (int k = 0; k < LockSlots; k++) begin
          if (held_valid[(first + k) % LockSlots] != want_lock) begin
            slot = SlotW'((first + k) % LockSlots);
            break;
          end
        end
        if (want_lock) begin
          cmd = ($urandom_range(0, 99) < 35) ? CMD_WRITE_LOCK : CMD_READ_LOCK;
        end else begin
          cmd = ($urandom_range(0, 7) == 0) ? CmdUnlockAlt : CMD_UNLOCK;
        end
      end
      send_request(cmd, slot, lo, hi);
    end
  endtask

  // Corner cases: empty unlocks, touching ranges, held slots, full-span and
  // inverted ranges, and the spare command code acting as an unlock.
  task automatic test_directed_cases();
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    send_request(CMD_UNLOCK,     4'd0,  32'h0,         32'h0);
    send_request(CmdUnlockAlt,   4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_READ_LOCK,  4'd0,  32'h100,       32'h1FF);
    send_request(CMD_READ_LOCK,  4'd1,  32'h1FF,       32'h2FF);
    send_request(CMD_WRITE_LOCK, 4'd2,  32'h1FF,       32'h1FF);
    send_request(CMD_WRITE_LOCK, 4'd2,  32'h300,       32'h3FF);
    send_request(CMD_READ_LOCK,  4'd3,  32'h3FF,       32'h400);
    send_request(CMD_READ_LOCK,  4'd0,  32'h9000,      32'h9001);
    send_request(CMD_WRITE_LOCK, 4'd1,  32'h300,       32'h300);
    send_request(CMD_UNLOCK,     4'd2,  32'hDEAD_BEEF, 32'h0);
    send_request(CMD_READ_LOCK,  4'd3,  32'h3FF,       32'h400);
    send_request(CMD_WRITE_LOCK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_READ_LOCK,  4'd14, 32'h0,         32'hFFFF_FFFF);
    send_request(CMD_WRITE_LOCK, 4'd13, 32'h500,       32'h100);
    send_request(CmdUnlockAlt,   4'd15, 32'h0,         32'h0);
    send_request(CMD_UNLOCK,     4'd15, 32'h0,         32'h0);
    send_request(CMD_WRITE_LOCK, 4'd15, 32'h0,         32'hFFFF_FFFF);
    send_request(CMD_UNLOCK,     4'd0,  32'h0,         32'h0);
    send_request(CmdUnlockAlt,   4'd1,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_UNLOCK,     4'd3,  32'h0,         32'h0);
    send_request(CMD_UNLOCK,     4'd13, 32'h0,         32'h0);
    send_request(CMD_WRITE_LOCK, 4'd15, 32'h0,         32'hFFFF_FFFF);
    send_request(CMD_READ_LOCK,  4'd7,  32'hAAAA_AAAA, 32'h5555_5555);
    send_request(CMD_UNLOCK,     4'd15, 32'h0,         32'h0);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    rx_mode = RX_ALWAYS;
    run_random_traffic(300);
  endtask

  task automatic test_sender_gaps();
    gaps_on = 1'b1;
    rx_mode = RX_ALWAYS;
    run_random_traffic(300);
  endtask

  task automatic test_receiver_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_BURSTY;
    run_random_traffic(300);
  endtask

  task automatic test_mixed_idling();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    run_random_traffic(500);
  endtask

  // Main sequence: reset, the tests in turn, then drain and verdict.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_idling();
    in_valid_i <= 1'b0;
    while (pending_answers_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_reader_writer_range_lock_table_unit OK");
    end else begin
      $display("tb_reader_writer_range_lock_table_unit NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rwrl_pkg.sv
rtl/rwrl_table.sv
rtl/reader_writer_range_lock_table_unit.sv
bench/tb_reader_writer_range_lock_table_unit.sv
